// ===== rtl/kaf_pkg.sv =====
// kaf_pkg: constants, register indexes and helpers for the kalman angle filter
// no dependencies; used by kalman_angle_filter_top
package kaf_pkg;

  localparam int unsigned FracBits = 24;
  localparam int unsigned MulW     = 36;   // signed multiplier operand width
  localparam int unsigned ResW     = 48;   // rounded product width
  localparam int unsigned SumW     = 50;   // width of exact sums before saturation
  localparam int unsigned QuoW     = 56;   // magnitude of p * 2^24
  localparam int unsigned DivRemW  = 34;

  localparam logic [23:0] ResetTimeStep    = 24'd50382;
  localparam logic [23:0] ResetAngleNoise  = 24'd16777;
  localparam logic [23:0] ResetBiasNoise   = 24'd50332;
  localparam logic [23:0] ResetMeasureNoise = 24'd503316;

  // 90 degrees in q16.16
  localparam logic signed [31:0] WrapLimit = 32'sd5898240;

  localparam logic [7:0] RegTimeStep     = 8'd0;
  localparam logic [7:0] RegAngleNoise   = 8'd1;
  localparam logic [7:0] RegBiasNoise    = 8'd2;
  localparam logic [7:0] RegMeasureNoise = 8'd3;
  localparam logic [7:0] RegWrapSnap     = 8'd4;

  function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(64'sh7FFFFFFF);
    lo = -SumW'(64'sh80000000);
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/kalman_angle_filter_top.sv =====
// kalman_angle_filter_top: two-state angle / rate-bias kalman filter
// one shared multiplier and one radix-2 divider under a small sequencer; uses kaf_pkg
//
// channel   dir  handshake                    payload
// s_*       in   s_tvalid / s_tready          s_tdata: measured_angle, measured_rate
// m_*       out  m_tvalid / m_tready          m_tdata: filtered_angle, rate_bias
// cfg_*     in   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// a normal update runs ten multiply steps and two 56-step restoring divisions
// for the gains, with setup and finish steps around them. the first word after
// reset and a wrap snap skip these and go straight to the finish step.
// rst is synchronous; it clears state, estimates and covariance and loads the config registers with reset values.
// input is not taken while an update is in flight; a finished word waits in the
// output register and only a stall there holds the sequencer at its last step.
module kalman_angle_filter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] measured_angle, [63:32] measured_rate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] filtered_angle, [63:32] rate_bias
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned MulW = kaf_pkg::MulW;
  localparam int unsigned ResW = kaf_pkg::ResW;
  localparam int unsigned SumW = kaf_pkg::SumW;
  localparam int unsigned QuoW = kaf_pkg::QuoW;
  localparam int unsigned RemW = kaf_pkg::DivRemW;

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M1   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_M3   = 5'd3;
  localparam logic [4:0] S_M4   = 5'd4;
  localparam logic [4:0] S_M5   = 5'd5;
  localparam logic [4:0] S_M6   = 5'd6;
  localparam logic [4:0] S_DSET = 5'd7;
  localparam logic [4:0] S_DRUN = 5'd8;
  localparam logic [4:0] S_DFIN = 5'd9;
  localparam logic [4:0] S_C1   = 5'd10;
  localparam logic [4:0] S_C2   = 5'd11;
  localparam logic [4:0] S_C3   = 5'd12;
  localparam logic [4:0] S_C4   = 5'd13;
  localparam logic [4:0] S_C5   = 5'd14;
  localparam logic [4:0] S_C6   = 5'd15;
  localparam logic [4:0] S_C7   = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0] state;

  // configuration registers
  logic [23:0] time_step;
  logic [23:0] angle_noise;
  logic [23:0] bias_noise;
  logic [23:0] measure_noise;
  logic        wrap_snap_enable;

  // filter state
  logic               started;
  logic signed [31:0] angle_est;
  logic signed [31:0] bias_est;
  logic signed [31:0] p00, p01, p10, p11;

  // working registers
  logic signed [31:0] meas;
  logic signed [32:0] rate;
  logic signed [31:0] ang;       // predicted angle
  logic signed [32:0] dtp;       // dt * p11, rounded
  logic signed [34:0] inner;
  logic signed [31:0] y;         // innovation
  logic signed [31:0] k0, k1;
  logic signed [ResW-1:0] mres;  // registered rounded product

  // divider
  logic                gsel;     // 0: gain k0, 1: gain k1
  logic [QuoW-1:0]     dnum;     // numerator shifting out, quotient shifting in
  logic [RemW-1:0]     drem;
  logic [32:0]         dden;
  logic                dneg;
  logic                dzero;
  logic [5:0]          dcnt;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  wire in_fire  = s_tvalid & s_tready;
  wire out_free = ~m_tvalid | m_tready;

  wire signed [31:0] in_angle = s_tdata[31:0];
  wire signed [31:0] in_rate  = s_tdata[63:32];

  // shared multiplier: operand select by sequencer step
  logic signed [MulW-1:0]   ma, mb;
  logic signed [2*MulW-1:0] prod;
  logic signed [2*MulW-1:0] prod_rnd;
  wire signed [MulW-1:0] dt_op = $signed({{(MulW-24){1'b0}}, time_step});

  always_comb begin
    ma = dt_op;
    mb = '0;
    case (state)
      S_M1: begin
        mb = $signed({{(MulW-33){rate[32]}}, rate});
      end
      S_M2: begin
        mb = $signed({{(MulW-32){p11[31]}}, p11});
      end
      S_M4: begin
        mb = $signed({{(MulW-35){inner[34]}}, inner});
      end
      S_M5: begin
        mb = $signed({{(MulW-24){1'b0}}, bias_noise});
      end
      S_C1, S_C2: begin
        ma = $signed({{(MulW-32){(state == S_C1) ? k0[31] : k1[31]}},
                      (state == S_C1) ? k0 : k1});
        mb = $signed({{(MulW-32){y[31]}}, y});
      end
      S_C3, S_C4: begin
        ma = $signed({{(MulW-32){k1[31]}}, k1});
        mb = (state == S_C3) ? $signed({{(MulW-32){p00[31]}}, p00})
                             : $signed({{(MulW-32){p01[31]}}, p01});
      end
      S_C5, S_C6: begin
        ma = $signed({{(MulW-32){k0[31]}}, k0});
        mb = (state == S_C5) ? $signed({{(MulW-32){p01[31]}}, p01})
                             : $signed({{(MulW-32){p00[31]}}, p00});
      end
      default: begin
        mb = '0;
      end
    endcase
    prod     = ma * mb;
    // round half up, then drop the fraction
    prod_rnd = (prod + (2*MulW)'(64'sd8388608)) >>> kaf_pkg::FracBits;
  end

  // sign-extended views for exact sums
  function automatic logic signed [SumW-1:0] sx32(input logic signed [31:0] v);
    sx32 = {{(SumW-32){v[31]}}, v};
  endfunction
  wire signed [SumW-1:0] mres_x = {{(SumW-ResW){mres[ResW-1]}}, mres};

  // innovation variance
  wire signed [32:0] s_var = {p00[31], p00} + $signed({9'd0, measure_noise});
  wire [31:0] p00_mag = p00[31] ? 32'(-p00) : 32'(p00);
  wire [31:0] p10_mag = p10[31] ? 32'(-p10) : 32'(p10);
  wire [32:0] s_mag   = s_var[32] ? 33'(-s_var) : 33'(s_var);

  // restoring step
  wire [RemW-1:0] d_trial = {drem[RemW-2:0], dnum[QuoW-1]};
  wire            d_ge    = (d_trial >= {1'b0, dden});
  wire [RemW-1:0] d_sub   = d_trial - {1'b0, dden};

  // quotient sign and saturation
  logic signed [31:0] dq;
  always_comb begin
    if (dzero) begin
      dq = '0;
    end else if (!dneg && (dnum > QuoW'(64'h7FFFFFFF))) begin
      dq = 32'sh7FFFFFFF;
    end else if (dneg && (dnum > QuoW'(64'h80000000))) begin
      dq = 32'sh80000000;
    end else if (dneg) begin
      dq = 32'(-dnum[31:0]);
    end else begin
      dq = dnum[31:0];
    end
  end

  wire wrap_hit = wrap_snap_enable &&
                  (((in_angle < -kaf_pkg::WrapLimit) && (angle_est > kaf_pkg::WrapLimit)) ||
                   ((in_angle > kaf_pkg::WrapLimit) && (angle_est < -kaf_pkg::WrapLimit)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      time_step        <= kaf_pkg::ResetTimeStep;
      angle_noise      <= kaf_pkg::ResetAngleNoise;
      bias_noise       <= kaf_pkg::ResetBiasNoise;
      measure_noise    <= kaf_pkg::ResetMeasureNoise;
      wrap_snap_enable <= 1'b0;
      started          <= 1'b0;
      angle_est        <= '0;
      bias_est         <= '0;
      p00              <= '0;
      p01              <= '0;
      p10              <= '0;
      p11              <= '0;
      m_tvalid         <= 1'b0;
      dcnt             <= '0;
      gsel             <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          kaf_pkg::RegTimeStep:     time_step        <= cfg_data[23:0];
          kaf_pkg::RegAngleNoise:   angle_noise      <= cfg_data[23:0];
          kaf_pkg::RegBiasNoise:    bias_noise       <= cfg_data[23:0];
          kaf_pkg::RegMeasureNoise: measure_noise    <= cfg_data[23:0];
          kaf_pkg::RegWrapSnap:     wrap_snap_enable <= cfg_data[0];
          default: ;
        endcase
      end

      // the finish step refills the output slot itself
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      mres <= prod_rnd[ResW-1:0];

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            meas <= in_angle;
            rate <= {in_rate[31], in_rate} - {bias_est[31], bias_est};
            if (!started) begin
              angle_est <= in_angle;
              started   <= 1'b1;
              state     <= S_DONE;
            end else if (wrap_hit) begin
              angle_est <= in_angle;
              state     <= S_DONE;
            end else begin
              state <= S_M1;
            end
          end
        end
        S_M1: begin
          state <= S_M2;
        end
        S_M2: begin
          ang   <= kaf_pkg::sat32(sx32(angle_est) + mres_x);
          state <= S_M3;
        end
        S_M3: begin
          dtp   <= mres[32:0];
          inner <= 35'(mres_x - sx32(p01) - sx32(p10) + $signed({26'd0, angle_noise}));
          state <= S_M4;
        end
        S_M4: begin
          p01   <= kaf_pkg::sat32(sx32(p01) - {{(SumW-33){dtp[32]}}, dtp});
          p10   <= kaf_pkg::sat32(sx32(p10) - {{(SumW-33){dtp[32]}}, dtp});
          state <= S_M5;
        end
        S_M5: begin
          p00   <= kaf_pkg::sat32(sx32(p00) + mres_x);
          state <= S_M6;
        end
        S_M6: begin
          p11   <= kaf_pkg::sat32(sx32(p11) + mres_x);
          y     <= kaf_pkg::sat32(sx32(meas) - sx32(ang));
          gsel  <= 1'b0;
          state <= S_DSET;
        end
        S_DSET: begin
          dnum  <= {(gsel ? p10_mag : p00_mag), 24'd0};
          drem  <= '0;
          dden  <= s_mag;
          dneg  <= (gsel ? p10[31] : p00[31]) ^ s_var[32];
          dzero <= (s_var == '0);
          dcnt  <= '0;
          state <= S_DRUN;
        end
        S_DRUN: begin
          drem  <= d_ge ? d_sub : d_trial;
          dnum  <= {dnum[QuoW-2:0], d_ge};
          dcnt  <= dcnt + 6'd1;
          if (dcnt == 6'(QuoW - 1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (gsel) begin
            k1    <= dq;
            state <= S_C1;
          end else begin
            k0    <= dq;
            gsel  <= 1'b1;
            state <= S_DSET;
          end
        end
        S_C1: begin
          state <= S_C2;
        end
        S_C2: begin
          angle_est <= kaf_pkg::sat32(sx32(ang) + mres_x);
          state     <= S_C3;
        end
        S_C3: begin
          bias_est <= kaf_pkg::sat32(sx32(bias_est) + mres_x);
          state    <= S_C4;
        end
        S_C4: begin
          p10   <= kaf_pkg::sat32(sx32(p10) - mres_x);
          state <= S_C5;
        end
        S_C5: begin
          p11   <= kaf_pkg::sat32(sx32(p11) - mres_x);
          state <= S_C6;
        end
        S_C6: begin
          p01   <= kaf_pkg::sat32(sx32(p01) - mres_x);
          state <= S_C7;
        end
        S_C7: begin
          p00   <= kaf_pkg::sat32(sx32(p00) - mres_x);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {bias_est, angle_est};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE)
    else $error("accepted word did not leave idle");

  // finishing with a free output slot presents a word
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> m_tvalid && state == S_IDLE)
    else $error("finished update not presented");

  // once started the filter stays started
  a_started: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped");

  // divider step count stays inside the quotient
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_DRUN |-> dcnt < 6'(QuoW))
    else $error("divider ran past quotient width");
`endif

endmodule
